// ===== hw/rtl/lerc_pkg.sv =====
// Shared constants, types and queue entry layout for the linear extrapolation
// residual block. No dependencies; every other file but lerc_ram imports this package.
package lerc_pkg;

	localparam int COORD_BITS = 16;
	localparam int MAX_COORDS = 16384;
	localparam int IN_W       = 16;
	localparam int QB_W       = 5;
	localparam int SYM_W      = 18;
	localparam int ADDR_W     = $clog2(MAX_COORDS);
	localparam int IDX_W      = $clog2(MAX_COORDS + 1);
	localparam int RES_W      = COORD_BITS + 3;
	localparam int HIST_W     = 2 * COORD_BITS;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [1:0] FRAMES_PRED = 2'd2;

	// One classified coordinate with both history values resolved.
	typedef struct packed {
		logic [COORD_BITS-1:0] value;
		logic [COORD_BITS-1:0] one_back;
		logic [COORD_BITS-1:0] two_back;
		logic [QB_W-1:0]       quant_bits;
		logic                  frame_end;
		logic                  is_raw;
		logic                  overflow;
	} lerc_item_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic                  empty;
	} lerc_qstat_t;

endpackage

// ===== hw/rtl/lerc_if.sv =====
// Valid/ready channel interfaces for coordinates in and symbols out.
// Depends on lerc_pkg for field widths.
interface lerc_in_if import lerc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] coord_value;
	logic [QB_W-1:0] quant_bits;
	logic            frame_end;

	modport source (output valid, coord_value, quant_bits, frame_end, input ready);
	modport sink   (input valid, coord_value, quant_bits, frame_end, output ready);
endinterface

interface lerc_out_if import lerc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SYM_W-1:0] symbol;
	logic                    is_raw;
	logic                    frame_end_out;
	logic                    capacity_overflow;

	modport source (output valid, symbol, is_raw, frame_end_out, capacity_overflow,
		input ready);
	modport sink   (input valid, symbol, is_raw, frame_end_out, capacity_overflow,
		output ready);
endinterface

// ===== hw/rtl/lerc_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module lerc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/lerc_front.sv =====
// Front end: accepts coordinates, tracks frame position, reads and updates
// the history RAM and hands resolved items to the queue. Uses lerc_pkg, lerc_ram.
module lerc_front import lerc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lerc_in_if.sink     coords,
	input  lerc_qstat_t qstat,
	output logic        push,
	output lerc_item_t  push_item
);
	logic [IDX_W-1:0]      coord_index_q;
	logic [1:0]            frames_seen_q;
	logic                  accept;
	logic                  ovf_now;
	logic                  fwd_now;

	logic                  valid_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [COORD_BITS-1:0] value_s1;
	logic [QB_W-1:0]       qb_s1;
	logic                  fe_s1;
	logic                  ovf_s1;
	logic                  raw_s1;
	logic                  fwd_s1;

	logic [COORD_BITS-1:0] last_one_q;
	logic [COORD_BITS-1:0] last_two_q;

	logic                  we;
	logic [HIST_W-1:0]     rdata;
	logic [COORD_BITS-1:0] h1;
	logic [COORD_BITS-1:0] h2;

	// Credit check: every item in flight has a queue slot waiting for it.
	assign coords.ready = ((FIFO_CNT_W+1)'(qstat.count) + (FIFO_CNT_W+1)'(valid_s1))
		< (FIFO_CNT_W+1)'(FIFO_DEPTH);
	assign accept  = coords.valid && coords.ready;
	assign ovf_now = coord_index_q >= IDX_W'(MAX_COORDS);
	// The item now in s1 writes the same entry this cycle; its read sees stale data.
	assign fwd_now = valid_s1 && !ovf_s1 && (addr_s1 == coord_index_q[ADDR_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_index_q <= '0;
			frames_seen_q <= '0;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (coords.frame_end) begin
					coord_index_q <= '0;
					if (frames_seen_q != FRAMES_PRED) begin
						frames_seen_q <= frames_seen_q + 2'd1;
					end
				end else if (!ovf_now) begin
					coord_index_q <= coord_index_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1  <= coord_index_q[ADDR_W-1:0];
			value_s1 <= coords.coord_value[COORD_BITS-1:0];
			qb_s1    <= coords.quant_bits;
			fe_s1    <= coords.frame_end;
			ovf_s1   <= ovf_now;
			raw_s1   <= ovf_now || (frames_seen_q != FRAMES_PRED);
			fwd_s1   <= fwd_now;
		end
		if (we) begin
			last_one_q <= value_s1;
			last_two_q <= h1;
		end
	end

	assign h1 = fwd_s1 ? last_one_q : rdata[COORD_BITS-1:0];
	assign h2 = fwd_s1 ? last_two_q : rdata[HIST_W-1:COORD_BITS];
	assign we = valid_s1 && !ovf_s1;

	lerc_ram #(
		.WIDTH (HIST_W),
		.DEPTH (MAX_COORDS)
	) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata ({h1, value_s1}),
		.re    (accept),
		.raddr (coord_index_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign push                 = valid_s1;
	assign push_item.value      = value_s1;
	assign push_item.one_back   = h1;
	assign push_item.two_back   = h2;
	assign push_item.quant_bits = qb_s1;
	assign push_item.frame_end  = fe_s1;
	assign push_item.is_raw     = raw_s1;
	assign push_item.overflow   = ovf_s1;
endmodule

// ===== hw/rtl/lerc_queue.sv =====
// Short register FIFO between front and back end.
// Uses lerc_pkg for the entry type and depth.
module lerc_queue import lerc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  lerc_item_t  push_item,
	input  logic        pop,
	output lerc_item_t  pop_item,
	output lerc_qstat_t qstat
);
	lerc_item_t            entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
		ptr_next = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item    = entries_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);
endmodule

// ===== hw/rtl/lerc_back.sv =====
// Back end: forms the prediction residual wrapped into the box range, or the raw value
// for raw items, and holds it in the output register. Uses lerc_pkg and lerc_out_if.
module lerc_back import lerc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  lerc_qstat_t qstat,
	input  lerc_item_t  item,
	output logic        pop,
	lerc_out_if.source  symbols
);
	logic                    out_valid_q;
	logic signed [SYM_W-1:0] symbol_q;
	logic                    is_raw_q;
	logic                    fe_q;
	logic                    ovf_q;

	logic signed [RES_W-1:0] pred;
	logic signed [RES_W-1:0] resid;
	logic signed [RES_W-1:0] half;
	logic signed [RES_W-1:0] box;
	logic signed [RES_W-1:0] wrapped;
	logic [QB_W-1:0]         qb;
	logic [SYM_W-1:0]        sym;

	assign pop = !qstat.empty && (!out_valid_q || symbols.ready);

	always_comb begin
		if (item.quant_bits == '0) begin
			qb = QB_W'(1);
		end else if (item.quant_bits > QB_W'(COORD_BITS)) begin
			qb = QB_W'(COORD_BITS);
		end else begin
			qb = item.quant_bits;
		end
		pred  = (RES_W'(item.one_back) <<< 1) - RES_W'(item.two_back);
		resid = RES_W'(item.value) - pred;
		half  = RES_W'(1) <<< (qb - QB_W'(1));
		box   = RES_W'(1) <<< qb;
		if (resid >= half) begin
			wrapped = resid - box;
		end else if (resid <= -half) begin
			wrapped = resid + box;
		end else begin
			wrapped = resid;
		end
		if (item.is_raw) begin
			sym = SYM_W'(item.value);
		end else begin
			sym = wrapped[SYM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (symbols.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			symbol_q <= sym;
			is_raw_q <= item.is_raw;
			fe_q     <= item.frame_end;
			ovf_q    <= item.overflow;
		end
	end

	assign symbols.valid             = out_valid_q;
	assign symbols.symbol            = symbol_q;
	assign symbols.is_raw            = is_raw_q;
	assign symbols.frame_end_out     = fe_q;
	assign symbols.capacity_overflow = ovf_q;
endmodule

// ===== hw/rtl/linear_extrapolation_residual.sv =====
// Top level of the second-order prediction residual block.
// Depends on lerc_pkg, lerc_if, lerc_front, lerc_queue and lerc_back.
//
// Channels: coords takes one quantised coordinate per transaction with its
// axis quantisation bits and an end-of-frame mark; symbols returns exactly
// one result per coordinate, in order.
// Coordinates of the first two frames come back raw; later ones come back as
// the residual against 2*previous - second previous, wrapped into the box of
// the axis. Coordinates past the history capacity come back raw and flagged.
// Path: an accepted coordinate passes the history RAM read, the queue and the
// output register before its symbol is valid. Throughput: one coordinate per
// cycle while the queue has room, set by the single read and single write per
// cycle of the history RAM; a coordinate whose read hits the entry being
// written in the same cycle takes the forwarded value.
// Reset clears the frame count and coordinate index; the history RAM is not
// cleared, and prediction starts only after two full frames, so an index that
// those frames did not both write reads stale data.
// When the receiver stalls, the output register holds its symbol and a
// four-entry queue absorbs items in flight; coords.ready falls once the queue
// has no free slot for a new coordinate.
module linear_extrapolation_residual import lerc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lerc_in_if.sink    coords,
	lerc_out_if.source symbols
);
	logic        push;
	logic        pop;
	lerc_item_t  push_item;
	lerc_item_t  pop_item;
	lerc_qstat_t qstat;

	lerc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.coords    (coords),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	lerc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	lerc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (qstat),
		.item    (pop_item),
		.pop     (pop),
		.symbols (symbols)
	);

	// The credit check must keep the queue from overrunning.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> qstat.count < FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue overrun");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue underrun");

	// A popped entry shows up on the output the next cycle.
	a_pop_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> symbols.valid)
		else $error("popped item not presented");

	a_ovf_raw: assert property (@(posedge clk) disable iff (!arst_n)
		symbols.valid && symbols.capacity_overflow |-> symbols.is_raw)
		else $error("overflow item not marked raw");
endmodule

// ===== verif/tb.sv =====
// Self-checking bench for linear_extrapolation_residual: random valid/ready traffic on
// both channels, scoreboarded against an in-bench second-order residual predictor.
// Depends on lerc_pkg, lerc_if and the RTL under hw/rtl.
module tb;
	import lerc_pkg::*;

	localparam int RANDOM_ITEMS   = 1630;
	localparam int MAX_LEN        = 48;
	localparam int QUIET_TAIL     = 200;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		logic [IN_W-1:0] value;
		logic [QB_W-1:0] qbits;
		logic            fe;
	} coord_t;

	typedef struct packed {
		logic signed [SYM_W-1:0] sym;
		logic                    raw;
		logic                    fe_out;
		logic                    ovf;
	} symbol_t;

	logic clk;
	logic arst_n;

	lerc_in_if  coords ();
	lerc_out_if symbols ();

	linear_extrapolation_residual u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.coords  (coords),
		.symbols (symbols)
	);

	coord_t  pending_coords [$];
	symbol_t expected_symbols [$];

	// residual predictor state
	logic [COORD_BITS-1:0] hist_one [MAX_COORDS];
	logic [COORD_BITS-1:0] hist_two [MAX_COORDS];
	int unsigned           frame_cnt;
	int unsigned           coord_pos;

	// stimulus shaping state
	int gen_one [MAX_COORDS];
	int gen_two [MAX_COORDS];
	int gen_pos;

	int total_items;
	int sent_cnt;
	int got_cnt;
	int err_cnt;
	int gap_left;
	int stall_left;
	int idle_cycles;

	function automatic void predict_symbol(coord_t c);
		symbol_t e;
		int      v;
		int      h1;
		int      h2;
		int      r;
		int      qb;
		int      half;
		v = int'(c.value) & ((1 << COORD_BITS) - 1);
		qb = int'(c.qbits);
		if (qb < 1)
			qb = 1;
		if (qb > COORD_BITS)
			qb = COORD_BITS;
		e.raw = 1'b1;
		e.ovf = 1'b0;
		e.fe_out = c.fe;
		r = v;
		if (coord_pos >= MAX_COORDS) begin
			e.ovf = 1'b1;
		end else begin
			h1 = int'(hist_one[coord_pos]);
			h2 = int'(hist_two[coord_pos]);
			if (frame_cnt >= 2) begin
				r = v - (2 * h1 - h2);
				half = 1 << (qb - 1);
				if (r >= half)
					r -= 2 * half;
				else if (r <= -half)
					r += 2 * half;
				e.raw = 1'b0;
			end
			hist_two[coord_pos] = h1[COORD_BITS-1:0];
			hist_one[coord_pos] = v[COORD_BITS-1:0];
			coord_pos++;
		end
		if (c.fe) begin
			coord_pos = 0;
			if (frame_cnt < 2)
				frame_cnt++;
		end
		e.sym = r[SYM_W-1:0];
		expected_symbols.insert(expected_symbols.size(), e);
	endfunction

	task automatic push_coord(int v, int qb, bit fe);
		coord_t c;
		c.value = v[IN_W-1:0];
		c.qbits = qb[QB_W-1:0];
		c.fe = fe;
		pending_coords.insert(pending_coords.size(), c);
		if (gen_pos < MAX_COORDS) begin
			gen_two[gen_pos] = gen_one[gen_pos];
			gen_one[gen_pos] = int'(c.value);
			gen_pos++;
		end
		if (fe)
			gen_pos = 0;
	endtask

	// Mostly smooth trajectories (small residuals), some jumps anywhere in range.
	task automatic add_frame(int len);
		int v;
		int qb;
		for (int k = 0; k < len; k++) begin
			if (gen_pos < MAX_COORDS && $urandom_range(0, 3) != 0)
				v = (2 * gen_one[gen_pos] - gen_two[gen_pos] + $urandom_range(0, 40) - 20)
					& 16'hFFFF;
			else
				v = $urandom_range(0, 65535);
			qb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
			push_coord(v, qb, k == len - 1);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		coords.valid = 1'b0;
		coords.coord_value = '0;
		coords.quant_bits = '0;
		coords.frame_end = 1'b0;
		symbols.ready = 1'b0;
		fork
			forever #5 clk = ~clk;
		join_none
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin : stimulus
		int  rand_items;
		int  len;
		frame_cnt = 0;
		coord_pos = 0;
		gen_pos = 0;
		sent_cnt = 0;
		got_cnt = 0;
		err_cnt = 0;
		gap_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		rand_items = 0;
		for (int i = 0; i < MAX_COORDS; i++) begin
			gen_one[i] = 0;
			gen_two[i] = 0;
		end

		// Two raw frames of the longest length; no later frame reads past them.
		add_frame(MAX_LEN);
		add_frame(MAX_LEN);

		// Full-scale swings at index 0, wrapped once in each direction.
		push_coord(0, 16, 1);
		push_coord(65535, 16, 1);
		push_coord(0, 16, 1);
		push_coord(65535, 16, 1);
		// zero quant bits clamp to one, out-of-range bits clamp to the coordinate width
		push_coord(65535, 0, 1);
		push_coord(65535, 31, 1);
		// residual exactly at +half and -half, then just inside
		push_coord(100, 4, 1);
		push_coord(100, 4, 1);
		push_coord(108, 4, 1);
		push_coord(108, 4, 1);
		push_coord(115, 4, 1);
		push_coord(115, 4, 1);
		// multi-coordinate frame
		push_coord(65535, 17, 0);
		push_coord(0, 1, 0);
		push_coord(12345, 16, 0);
		push_coord(32768, 8, 1);

		while (rand_items < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
				: $urandom_range(1, MAX_LEN);
			add_frame(len);
			rand_items += len;
		end
		total_items = pending_coords.size();

		wait (arst_n);
		do
			@(negedge clk);
		while (pending_coords.size() != 0 || coords.valid || expected_symbols.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		coord_t nxt;
		if (!arst_n) begin
			coords.valid <= 1'b0;
			coords.coord_value <= '0;
			coords.quant_bits <= '0;
			coords.frame_end <= 1'b0;
			gap_left = 0;
		end else begin
			if (coords.valid && coords.ready) begin
				predict_symbol(coord_t'{coords.coord_value, coords.quant_bits, coords.frame_end});
				sent_cnt++;
			end
			if (!coords.valid || coords.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					coords.valid <= 1'b0;
				end else if (pending_coords.size() == 0) begin
					coords.valid <= 1'b0;
				end else if (pending_coords.size() > QUIET_TAIL && (sent_cnt / 512) % 3 != 2
					&& $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 16);
					coords.valid <= 1'b0;
				end else begin
					nxt = pending_coords[0];
					pending_coords.delete(0);
					coords.valid <= 1'b1;
					coords.coord_value <= nxt.value;
					coords.quant_bits <= nxt.qbits;
					coords.frame_end <= nxt.fe;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		symbol_t want;
		if (!arst_n) begin
			symbols.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (symbols.valid && symbols.ready) begin
				got_cnt++;
				if (expected_symbols.size() == 0) begin
					$error("symbol %0d with no coordinate pending", symbols.symbol);
					err_cnt++;
				end else begin
					want = expected_symbols[0];
					expected_symbols.delete(0);
					if (symbols.symbol !== want.sym) begin
						$error("symbol: expected %0d, got %0d", want.sym, symbols.symbol);
						err_cnt++;
					end
					if (symbols.is_raw !== want.raw) begin
						$error("is_raw: expected %0b, got %0b", want.raw, symbols.is_raw);
						err_cnt++;
					end
					if (symbols.frame_end_out !== want.fe_out) begin
						$error("frame_end_out: expected %0b, got %0b", want.fe_out,
							symbols.frame_end_out);
						err_cnt++;
					end
					if (symbols.capacity_overflow !== want.ovf) begin
						$error("capacity_overflow: expected %0b, got %0b", want.ovf,
							symbols.capacity_overflow);
						err_cnt++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				symbols.ready <= 1'b0;
			end else if (got_cnt < total_items - QUIET_TAIL && (got_cnt / 640) % 3 != 1
				&& $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 16);
				symbols.ready <= 1'b0;
			end else begin
				symbols.ready <= 1'b1;
			end
		end
	end

	// End the run if neither channel moves a transaction for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((coords.valid && coords.ready) || (symbols.valid && symbols.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
